/* design/bole_pkg.sv */
// ----------------------------------------------------------------------------
// bole_pkg
// Op codes, status codes and sequencer states of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

   localparam logic [3:0] OP_INS_HEAD = 4'd0;
   localparam logic [3:0] OP_INS_TAIL = 4'd1;
   localparam logic [3:0] OP_INS_POS  = 4'd2;
   localparam logic [3:0] OP_DEL_HEAD = 4'd3;
   localparam logic [3:0] OP_DEL_TAIL = 4'd4;
   localparam logic [3:0] OP_DEL_POS  = 4'd5;
   localparam logic [3:0] OP_SEARCH   = 4'd6;
   localparam logic [3:0] OP_CLEAR    = 4'd7;
   localparam logic [3:0] OP_TRAVERSE = 4'd8;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_BAD_POS   = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_INS_PUT,
      S_DEL_RD,
      S_DEL_WR,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_TRAV_RD,
      S_TRAV_OUT,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

/* design/bole_store.sv */
// ----------------------------------------------------------------------------
// bole_store
// Word store of the list: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bole_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/bounded_ordered_list_engine.sv */
// Refused ops and clear go straight to the result; insert and delete move each
// shifted entry with a store read then a write; search reads and compares each
// entry in turn; traverse reads each element and sends it out. One item at a
// time. Reset empties the list at once (count only).
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// Ordered list of signed words with positional insert, delete and search.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_ordered_list_engine
   import bole_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_op,
   input  wire logic [31:0] req_value,
   input  wire logic [7:0]  req_position,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_element,
   output logic [4:0]       rsp_where_found,
   output logic [4:0]       rsp_size_now,
   output logic             rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   state_type       state_ff, state_in, dec_state;
   logic [CW-1:0]   count_ff, count_in, dec_count;
   logic [AW-1:0]   cur_ff, cur_in, dec_cur;
   logic [AW-1:0]   idx_ff, idx_in, dec_idx;
   logic [31:0]     val_ff, val_in;
   logic [2:0]      status_ff, status_in, dec_status;
   logic [4:0]      where_ff, where_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_status_ff, rsp_status_in;
   logic [31:0]     rsp_element_ff, rsp_element_in;
   logic [4:0]      rsp_where_ff, rsp_where_in;
   logic [4:0]      rsp_size_ff, rsp_size_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [31:0]     wr_data, rd_data;

   logic            accept, out_free, hit;
   logic [31:0]     cnt32, pos32, cur32, idx32, dec_idx32;
   logic [4:0]      count_ext;

   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cnt32     = 32'(count_ff);
   assign pos32     = 32'(req_position);
   assign cur32     = 32'(cur_ff);
   assign idx32     = 32'(idx_ff);
   assign count_ext = 5'(count_in);
   // compare unit used by search
   assign hit       = (rd_data == val_ff);

   // Decode of a new item
   always_comb begin
      dec_state  = S_RESULT;
      dec_status = ST_OK;
      dec_count  = count_ff;
      dec_idx32  = 32'd0;
      dec_cur    = '0;
      if (req_op inside {OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS}) begin
         if (req_op == OP_INS_TAIL) begin
            dec_idx32 = cnt32;
         end else if (req_op == OP_INS_POS) begin
            dec_idx32 = pos32 - 32'd1;
         end
         dec_cur = AW'(cnt32);
         if (cnt32 >= 32'(DEPTH)) begin
            dec_status = ST_FULL;
         end else if (req_op == OP_INS_POS && (pos32 < 32'd1 || pos32 > cnt32 + 32'd1)) begin
            dec_status = ST_BAD_POS;
         end else if (dec_idx32 == cnt32) begin
            dec_state = S_INS_PUT;
         end else begin
            dec_state = S_INS_RD;
         end
      end else if (req_op inside {OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS}) begin
         if (req_op == OP_DEL_TAIL) begin
            dec_idx32 = cnt32 - 32'd1;
         end else if (req_op == OP_DEL_POS) begin
            dec_idx32 = pos32 - 32'd1;
         end
         dec_cur = AW'(dec_idx32);
         if (cnt32 == 32'd0) begin
            dec_status = ST_EMPTY;
         end else if (req_op == OP_DEL_POS && (pos32 < 32'd1 || pos32 > cnt32)) begin
            dec_status = ST_BAD_POS;
         end else if (dec_idx32 + 32'd1 >= cnt32) begin
            dec_count = count_ff - CW'(1);
         end else begin
            dec_state = S_DEL_RD;
         end
      end else if (req_op == OP_SEARCH) begin
         dec_status = ST_NOT_FOUND;
         if (cnt32 != 32'd0) begin
            dec_state = S_SRCH_RD;
         end
      end else if (req_op == OP_CLEAR) begin
         if (cnt32 == 32'd0) begin
            dec_status = ST_EMPTY;
         end
         dec_count = '0;
      end else if (req_op == OP_TRAVERSE) begin
         if (cnt32 == 32'd0) begin
            dec_status = ST_EMPTY;
         end else begin
            dec_state = S_TRAV_RD;
         end
      end
      dec_idx = AW'(dec_idx32);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = dec_state;
            end
         end
         S_INS_RD:  state_in = S_INS_WR;
         S_INS_WR: begin
            if (cur32 - 32'd1 == idx32) begin
               state_in = S_INS_PUT;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_PUT: state_in = S_RESULT;
         S_DEL_RD:  state_in = S_DEL_WR;
         S_DEL_WR: begin
            if (cur32 + 32'd2 >= cnt32) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_DEL_RD;
            end
         end
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (hit || cur32 + 32'd1 == cnt32) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_SRCH_RD;
            end
         end
         S_TRAV_RD: state_in = S_TRAV_OUT;
         S_TRAV_OUT: begin
            if (out_free) begin
               if (cur32 + 32'd1 == cnt32) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_TRAV_RD;
               end
            end
         end
         S_RESULT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      count_in       = count_ff;
      cur_in         = cur_ff;
      idx_in         = idx_ff;
      val_in         = val_ff;
      status_in      = status_ff;
      where_in       = where_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_where_in   = rsp_where_ff;
      rsp_size_in    = rsp_size_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = rd_data;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               count_in  = dec_count;
               cur_in    = dec_cur;
               idx_in    = dec_idx;
               val_in    = req_value;
               status_in = dec_status;
               where_in  = '0;
            end
         end
         S_INS_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(cur32 - 32'd1);
         end
         S_INS_WR: begin
            wr_en  = 1'b1;
            cur_in = AW'(cur32 - 32'd1);
         end
         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = val_ff;
            count_in = count_ff + CW'(1);
         end
         S_DEL_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(cur32 + 32'd1);
         end
         S_DEL_WR: begin
            wr_en  = 1'b1;
            cur_in = AW'(cur32 + 32'd1);
            if (cur32 + 32'd2 >= cnt32) begin
               count_in = count_ff - CW'(1);
            end
         end
         S_SRCH_RD: begin
            rd_en = 1'b1;
         end
         S_SRCH_CMP: begin
            if (hit) begin
               status_in = ST_OK;
               where_in  = 5'(cur32 + 32'd1);
            end else begin
               cur_in = AW'(cur32 + 32'd1);
            end
         end
         S_TRAV_RD: begin
            rd_en = 1'b1;
         end
         S_TRAV_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_element_in = rd_data;
               rsp_where_in   = 5'(cur32 + 32'd1);
               rsp_size_in    = count_ext;
               rsp_last_in    = (cur32 + 32'd1 == cnt32);
               cur_in         = AW'(cur32 + 32'd1);
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_element_in = 32'd0;
               rsp_where_in   = where_ff;
               rsp_size_in    = count_ext;
               rsp_last_in    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff         <= cur_in;
      idx_ff         <= idx_in;
      val_ff         <= val_in;
      status_ff      <= status_in;
      where_ff       <= where_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_where_ff   <= rsp_where_in;
      rsp_size_ff    <= rsp_size_in;
      rsp_last_ff    <= rsp_last_in;
   end

   bole_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_where_found = rsp_where_ff;
   assign rsp_size_now    = rsp_size_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

/* test/tb_bounded_ordered_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_engine
// Self-checking bench for the ordered list engine. A shadow copy of the list
// predicts every result of each accepted operation; results are compared
// field by field in order. Directed corner cases come first, then random
// phases that grow, shrink or churn the list, with random gaps on both sides.
// ----------------------------------------------------------------------------

module tb_bounded_ordered_list_engine;
   import bole_pkg::*;

   localparam int          LIST_DEPTH    = 16;
   localparam int          STIM_ITEMS    = 270;
   localparam int          PHASE_ITEMS   = 40;
   localparam int          WATCHDOG_MAX  = 2000;
   localparam int          DRAIN_CYCLES  = 80;
   localparam logic [3:0]  OP_UNUSED_LO  = 4'd9;
   localparam logic [3:0]  OP_UNUSED_HI  = 4'd15;
   localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX      = 32'h7fff_ffff;

   localparam int PH_GROW   = 0;
   localparam int PH_SHRINK = 1;
   localparam int PH_CHURN  = 2;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] element;
      logic [4:0]  where_found;
      logic [4:0]  size_now;
      logic        last;
   } list_result_t;

   class list_shadow;
      logic [31:0]  words [LIST_DEPTH];
      int unsigned  count;
      list_result_t expected_q [$];
      int           error_count;
      int           results_checked;
      int           full_refusals;

      function new();
         count           = 0;
         error_count     = 0;
         results_checked = 0;
         full_refusals   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void queue_result(logic [2:0] status, logic [31:0] element,
                                 int unsigned where, logic last);
         list_result_t r;
         r.status      = status;
         r.element     = element;
         r.where_found = where[4:0];
         r.size_now    = count[4:0];
         r.last        = last;
         expected_q.push_back(r);
      endfunction

      function void shift_in(int unsigned idx, logic [31:0] value);
         for (int unsigned i = count; i > idx; i--)
            words[i] = words[i - 1];
         words[idx] = value;
         count++;
      endfunction

      function void shift_out(int unsigned idx);
         for (int unsigned i = idx; i + 1 < count; i++)
            words[i] = words[i + 1];
         count--;
      endfunction

      // Note an accepted operation: update the shadow list, queue its results.
      function void apply_op(logic [3:0] op, logic [31:0] value, logic [7:0] position);
         logic [2:0]  status;
         int unsigned where;
         status = ST_OK;
         where  = 0;
         case (op)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
               if (count >= LIST_DEPTH) begin
                  status = ST_FULL;
                  full_refusals++;
               end else if (op == OP_INS_HEAD) begin
                  shift_in(0, value);
               end else if (op == OP_INS_TAIL) begin
                  shift_in(count, value);
               end else if (position < 1 || position > count + 1) begin
                  status = ST_BAD_POS;
               end else begin
                  shift_in(position - 1, value);
               end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
               if (count == 0) begin
                  status = ST_EMPTY;
               end else if (op == OP_DEL_HEAD) begin
                  shift_out(0);
               end else if (op == OP_DEL_TAIL) begin
                  shift_out(count - 1);
               end else if (position < 1 || position > count) begin
                  status = ST_BAD_POS;
               end else begin
                  shift_out(position - 1);
               end
            end
            OP_SEARCH: begin
               status = ST_NOT_FOUND;
               // keep the first match only
               for (int unsigned i = 0; i < count; i++) begin
                  if (status == ST_NOT_FOUND && words[i] == value) begin
                     status = ST_OK;
                     where  = i + 1;
                  end
               end
            end
            OP_CLEAR: begin
               if (count == 0)
                  status = ST_EMPTY;
               count = 0;
            end
            OP_TRAVERSE: begin
               if (count == 0) begin
                  status = ST_EMPTY;
               end else begin
                  for (int unsigned i = 0; i < count; i++)
                     queue_result(ST_OK, words[i], i + 1, i + 1 == count);
                  return;
               end
            end
            default: ;
         endcase
         queue_result(status, '0, where, 1'b1);
      endfunction

      function void check_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, got %0d",
                     $time, name, $signed(want), $signed(got));
            error_count++;
         end
      endfunction

      function void check_result(list_result_t got);
         list_result_t want;
         results_checked++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: status=%0d element=%0d where=%0d size=%0d last=%0d",
                     $time, got.status, $signed(got.element), got.where_found,
                     got.size_now, got.last);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         check_field("status", want.status, got.status);
         check_field("element", want.element, got.element);
         check_field("where_found", want.where_found, got.where_found);
         check_field("size_now", want.size_now, got.size_now);
         check_field("last", want.last, got.last);
      endfunction
   endclass

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [3:0]  req_op       = OP_INS_HEAD;
   logic [31:0] req_value    = '0;
   logic [7:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_element;
   logic [4:0]  rsp_where_found;
   logic [4:0]  rsp_size_now;
   logic        rsp_last;

   bit          tx_idle      = 1'b1;
   bit          rx_idle      = 1'b1;
   int          rx_hold      = 0;
   int          idle_cycles  = 0;
   int          ops_sent     = 0;
   int          ignored_sent = 0;
   list_shadow  shadow;

   bounded_ordered_list_engine #(
      .DEPTH (LIST_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_where_found (rsp_where_found),
      .rsp_size_now    (rsp_size_now),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Result side: check each accepted item, then hold stall for a random gap.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            shadow.check_result({rsp_status, rsp_element, rsp_where_found,
                                 rsp_size_now, rsp_last});
            rx_hold = rx_idle ? $urandom_range(0, 14) : 0;
         end else if (rx_hold > 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold > 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_MAX);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Keep valid high across back-to-back items; drop it only for a real gap.
   task automatic send_item(logic [3:0] op, logic [31:0] value, logic [7:0] position);
      int gap;
      gap = tx_idle ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_value    <= value;
      req_position <= position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.apply_op(op, value, position);
      if (op > OP_TRAVERSE)
         ignored_sent++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return '1;
         4, 5, 6: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   // Mostly a legal position, sometimes just past the end or anywhere.
   function automatic logic [7:0] pick_position(int unsigned limit);
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'(limit + 1);
         2: return 8'($urandom_range(0, 255));
         default: return (limit == 0) ? 8'd0 : 8'($urandom_range(1, limit));
      endcase
   endfunction

   initial begin
      int          phase_kind;
      int          phase_left;
      int          roll;
      int          ins_pct;
      int          del_pct;
      logic [3:0]  op;
      logic [31:0] value;
      logic [7:0]  position;

      shadow     = new();
      phase_kind = PH_GROW;
      phase_left = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corner cases on an empty list
      send_item(OP_TRAVERSE, '0, 8'd0);
      send_item(OP_DEL_HEAD, '0, 8'd0);
      send_item(OP_DEL_TAIL, '0, 8'd0);
      send_item(OP_DEL_POS, '0, 8'd1);
      send_item(OP_SEARCH, '0, 8'd0);
      send_item(OP_CLEAR, '0, 8'd0);
      send_item(OP_INS_POS, 32'd1, 8'd0);
      send_item(OP_INS_POS, 32'd1, 8'd2);
      // build a short list with extreme words and a duplicate
      send_item(OP_INS_POS, WORD_MIN, 8'd1);
      send_item(OP_INS_HEAD, WORD_MAX, 8'd0);
      send_item(OP_INS_TAIL, '0, 8'd0);
      send_item(OP_INS_POS, '1, 8'd4);
      send_item(OP_INS_POS, 32'd5, 8'd2);
      send_item(OP_INS_TAIL, 32'd5, 8'd0);
      send_item(OP_SEARCH, 32'd5, 8'd0);
      send_item(OP_SEARCH, 32'h1234_5678, 8'd0);
      send_item(OP_DEL_POS, '0, 8'd0);
      send_item(OP_DEL_POS, '0, 8'd255);
      send_item(OP_DEL_POS, '0, 8'd7);
      send_item(OP_DEL_POS, '0, 8'd3);
      send_item(OP_UNUSED_LO, WORD_MAX, 8'd255);
      send_item(OP_UNUSED_HI, WORD_MIN, 8'd255);
      send_item(OP_TRAVERSE, '0, 8'd0);
      send_item(OP_DEL_HEAD, '0, 8'd0);
      send_item(OP_DEL_TAIL, '0, 8'd0);
      send_item(OP_CLEAR, '0, 8'd0);

      while (ops_sent < STIM_ITEMS) begin
         if (phase_left == 0) begin
            phase_left = PHASE_ITEMS;
            if (ops_sent > 0)
               phase_kind = $urandom_range(PH_GROW, PH_CHURN);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
         end
         phase_left--;

         case (phase_kind)
            PH_GROW: begin
               ins_pct = 65;
               del_pct = 10;
            end
            PH_SHRINK: begin
               ins_pct = 15;
               del_pct = 60;
            end
            default: begin
               ins_pct = 40;
               del_pct = 35;
            end
         endcase

         roll = $urandom_range(0, 99);
         if (roll < ins_pct) begin
            case ($urandom_range(0, 2))
               0: op = OP_INS_HEAD;
               1: op = OP_INS_TAIL;
               default: op = OP_INS_POS;
            endcase
         end else if (roll < ins_pct + del_pct) begin
            case ($urandom_range(0, 2))
               0: op = OP_DEL_HEAD;
               1: op = OP_DEL_TAIL;
               default: op = OP_DEL_POS;
            endcase
         end else if (roll < ins_pct + del_pct + 10) begin
            op = OP_SEARCH;
         end else if (roll < ins_pct + del_pct + 18) begin
            op = OP_TRAVERSE;
         end else if (roll < ins_pct + del_pct + 21) begin
            // never clear while filling, so grow phases reach a full list
            op = (phase_kind == PH_GROW) ? OP_SEARCH : OP_CLEAR;
         end else begin
            op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end

         if (op == OP_SEARCH && shadow.count > 0 && $urandom_range(0, 1) == 1)
            value = shadow.words[$urandom_range(0, shadow.count - 1)];
         else
            value = pick_value();
         position = pick_position(op == OP_INS_POS ? shadow.count + 1 : shadow.count);

         send_item(op, value, position);
         if (op <= OP_TRAVERSE)
            ops_sent++;
      end
      req_valid <= 1'b0;

      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d random list operations plus %0d ignored codes, %0d results checked",
               ops_sent, ignored_sent, shadow.results_checked);
      $display("Inserts refused on a full list: %0d", shadow.full_refusals);
      if (shadow.error_count == 0 && shadow.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* bounded_ordered_list_engine.f */
design/bole_pkg.sv
design/bole_store.sv
design/bounded_ordered_list_engine.sv
test/tb_bounded_ordered_list_engine.sv
